FILE: sv/cti_pkg.sv
`default_nettype none

package cti_pkg;

	localparam int ACTION_W = 2;
	localparam int SECTOR_W = 4;
	localparam int SUBSEC_W = 3;
	localparam int ETABIN_W = 4;
	localparam int ENERGY_W = 16;
	localparam int ADC_W    = 9;
	localparam int RING_W   = 12;
	localparam int WIN_W    = 13;
	// window accumulator: 24 towers of 511 need 14 bits before saturation
	localparam int WACC_W   = 14;
	localparam int LIMIT_W  = 13;
	localparam int FRAC_W   = 4;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_HIT   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

	localparam logic [LIMIT_W-1:0] ISO_LIMIT_RST   = 13'd0;
	localparam logic [LIMIT_W-1:0] STORE_LIMIT_RST = 13'd256;

	localparam logic REG_ISO_LIMIT   = 1'b0;
	localparam logic REG_STORE_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_QUERY,
		ST_LAST,
		ST_DONE
	} cti_state_t;

	// tag that travels with one grid read of a query
	typedef struct packed {
		logic start;    // new query, zero the sums
		logic valid;    // read data belongs to a window position
		logic in_grid;  // position lies inside the grid
		logic centre;   // centre tower
		logic ring;     // one of the eight adjacent towers
	} cti_acc_ctl_t;

endpackage

`default_nettype wire

FILE: sv/cti_grid_mem.sv
`default_nettype none

module cti_grid_mem
	import cti_pkg::*;
#(
	parameter int DEPTH = 720,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [ADC_W-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [ADC_W-1:0]   rdata
);

	logic [ADC_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/cti_window_acc.sv
`default_nettype none

module cti_window_acc
	import cti_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cti_acc_ctl_t     ctl,
	input  wire logic [ADC_W-1:0] rdata,
	output logic [ADC_W-1:0]      centre,
	output logic [RING_W-1:0]     ring_sum,
	output logic [WACC_W-1:0]     window_sum
);

	logic [ADC_W-1:0]  centre_q;
	logic [RING_W-1:0] ring_q;
	logic [WACC_W-1:0] window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q <= '0;
			ring_q   <= '0;
			window_q <= '0;
		end else if (ctl.start) begin
			centre_q <= '0;
			ring_q   <= '0;
			window_q <= '0;
		end else if (ctl.valid && ctl.in_grid) begin
			if (ctl.centre) begin
				centre_q <= rdata;
			end else begin
				window_q <= window_q + WACC_W'(rdata);
				if (ctl.ring) begin
					ring_q <= ring_q + RING_W'(rdata);
				end
			end
		end
	end

	assign centre     = centre_q;
	assign ring_sum   = ring_q;
	assign window_sum = window_q;

endmodule

`default_nettype wire

FILE: sv/cti_apb_regs.sv
`default_nettype none

module cti_apb_regs
	import cti_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready,
	output logic [LIMIT_W-1:0]     iso_limit,
	output logic [LIMIT_W-1:0]     store_limit
);

	logic [LIMIT_W-1:0] iso_limit_q;
	logic [LIMIT_W-1:0] store_limit_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_limit_q   <= ISO_LIMIT_RST;
			store_limit_q <= STORE_LIMIT_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_STORE_LIMIT) begin
				store_limit_q <= pwdata[LIMIT_W-1:0];
			end else begin
				iso_limit_q <= pwdata[LIMIT_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_STORE_LIMIT) begin
			prdata = APB_DW'(store_limit_q);
		end else begin
			prdata = APB_DW'(iso_limit_q);
		end
	end

	assign iso_limit   = iso_limit_q;
	assign store_limit = store_limit_q;

endmodule

`default_nettype wire

FILE: sv/calorimeter_tower_isolation.sv
// Query: once accepted, a query walks the 25 window positions, reading the grid through
//   its single read port at those inside it, then registers the sums; no new request is
//   taken until the result is loaded, which waits while the output stalls.
// Hit and unused requests are taken back to back; a clear stalls for the clearing pass.
// Reset: control and configuration registers return to defaults, then a clearing pass
//   zeroes all ETA_BINS*PHI_BINS grid cells (720 by default) while in_stall stays high.
`default_nettype none

module calorimeter_tower_isolation
	import cti_pkg::*;
#(
	parameter int ETA_BINS   = 12,
	parameter int PHI_BINS   = 60,
	parameter int SUBSECTORS = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// request channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [SECTOR_W-1:0] sector,
	input  wire logic [SUBSEC_W-1:0] subsector,
	input  wire logic [ETABIN_W-1:0] eta_bin,
	input  wire logic [ENERGY_W-1:0] energy,
	// result channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [ADC_W-1:0]         tower_value,
	output logic [RING_W-1:0]        ring_sum,
	output logic [WIN_W-1:0]         window_sum,
	output logic                     ring_isolated,
	output logic                     window_isolated,
	// configuration
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [APB_AW-1:0]   paddr,
	input  wire logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]        prdata,
	output logic                     pready
);

	localparam int GRID = ETA_BINS * PHI_BINS;
	localparam int AW   = $clog2(GRID);
	// signed tower coordinates, wide enough for one-based fields going to -1 and window offsets
	localparam int EW   = 8;
	localparam int PW   = 10;

	// ---------------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------------
	logic [LIMIT_W-1:0] iso_limit;
	logic [LIMIT_W-1:0] store_limit;

	cti_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.iso_limit   (iso_limit),
		.store_limit (store_limit)
	);

	// ---------------------------------------------------------------------
	// control state
	// ---------------------------------------------------------------------
	cti_state_t state_q, state_d;
	logic [AW-1:0] sweep_q;        // clearing pass address
	logic [2:0]    de_q, dp_q;     // window position, 0..4 each, 2 is the centre
	logic signed [EW-1:0] eta_c_q; // queried tower
	logic signed [PW-1:0] phi_c_q;
	logic          out_valid_q;
	logic [ADC_W-1:0]  tower_value_q;
	logic [RING_W-1:0] ring_sum_q;
	logic [WIN_W-1:0]  window_sum_q;
	logic          ring_iso_q, window_iso_q;

	logic accept, out_free, last_pos;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign last_pos = (de_q == 3'd4) && (dp_q == 3'd4);

	// ---------------------------------------------------------------------
	// request decode: tower address from sector, subsector and eta bin
	// ---------------------------------------------------------------------
	logic signed [EW-1:0] eta_in;
	logic signed [PW-1:0] phi_in;
	logic signed [PW-1:0] sec_m1;
	logic                 hit_in_grid;
	logic [AW-1:0]        hit_addr;
	logic [ENERGY_W:0]    store_raw;   // store_limit in raw units, 17 bits
	logic [ENERGY_W:0]    adc_full;
	logic [ADC_W-1:0]     adc_sat;
	logic                 hit_store;

	assign sec_m1 = $signed(PW'(sector)) - $signed(PW'(1));
	assign phi_in = sec_m1 * $signed(PW'(SUBSECTORS)) + $signed(PW'(subsector));
	assign eta_in = $signed(EW'(eta_bin)) - $signed(EW'(1));

	assign hit_in_grid = !eta_in[EW-1] && (eta_in < $signed(EW'(ETA_BINS)))
		&& !phi_in[PW-1] && (phi_in < $signed(PW'(PHI_BINS)));
	assign hit_addr = AW'(AW'(eta_in) * AW'(PHI_BINS) + AW'(phi_in));

	// round half up, saturate to the 9-bit ADC range
	assign store_raw = {store_limit, {FRAC_W{1'b0}}};
	assign adc_full  = ((ENERGY_W+1)'(energy) + (ENERGY_W+1)'(8)) >> FRAC_W;
	assign adc_sat   = (adc_full > (ENERGY_W+1)'({ADC_W{1'b1}})) ? {ADC_W{1'b1}}
		: adc_full[ADC_W-1:0];
	assign hit_store = accept && (action == ACT_HIT) && hit_in_grid
		&& ((ENERGY_W+1)'(energy) < store_raw);

	// ---------------------------------------------------------------------
	// window walk: one window position per cycle, 5x5 around the queried tower
	// ---------------------------------------------------------------------
	logic signed [EW-1:0] q_eta;
	logic signed [PW-1:0] q_phi;
	logic                 q_in_grid;
	logic [AW-1:0]        q_addr;
	logic                 q_centre, q_ring;

	assign q_eta = eta_c_q + $signed(EW'(de_q)) - $signed(EW'(2));
	assign q_phi = phi_c_q + $signed(PW'(dp_q)) - $signed(PW'(2));
	assign q_in_grid = !q_eta[EW-1] && (q_eta < $signed(EW'(ETA_BINS)))
		&& !q_phi[PW-1] && (q_phi < $signed(PW'(PHI_BINS)));
	assign q_addr   = AW'(AW'(q_eta) * AW'(PHI_BINS) + AW'(q_phi));
	assign q_centre = (de_q == 3'd2) && (dp_q == 3'd2);
	assign q_ring   = !q_centre && (de_q >= 3'd1) && (de_q <= 3'd3)
		&& (dp_q >= 3'd1) && (dp_q <= 3'd3);

	// ---------------------------------------------------------------------
	// grid memory: sweep writes zeros, hits write the rounded ADC
	// ---------------------------------------------------------------------
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr;
	logic [ADC_W-1:0] mem_wdata, mem_rdata;

	cti_grid_mem #(
		.DEPTH (GRID),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (q_addr),
		.rdata (mem_rdata)
	);

	// ---------------------------------------------------------------------
	// next state
	// ---------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_q == AW'(GRID - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && action == ACT_CLEAR) begin
					state_d = ST_CLEAR;
				end else if (accept && action == ACT_QUERY) begin
					state_d = ST_QUERY;
				end
			end
			ST_QUERY: begin
				if (last_pos) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// outputs of the state machine
	// ---------------------------------------------------------------------
	always_comb begin
		in_stall  = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = hit_addr;
		mem_wdata = adc_sat;
		mem_re    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				mem_we   = hit_store;
			end
			ST_QUERY: begin
				mem_re = q_in_grid;
			end
			ST_LAST, ST_DONE: begin
				in_stall = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
			de_q    <= '0;
			dp_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				sweep_q <= sweep_q + AW'(1);
			end else if (accept && action == ACT_CLEAR) begin
				sweep_q <= '0;
			end
			if (accept && action == ACT_QUERY) begin
				de_q <= '0;
				dp_q <= '0;
			end else if (state_q == ST_QUERY) begin
				if (dp_q == 3'd4) begin
					dp_q <= '0;
					de_q <= de_q + 3'd1;
				end else begin
					dp_q <= dp_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action == ACT_QUERY) begin
			eta_c_q <= eta_in;
			phi_c_q <= phi_in;
		end
	end

	// tag for the read in flight, lines up with mem_rdata
	cti_acc_ctl_t tag_s1;
	cti_acc_ctl_t acc_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.start   <= 1'b0;
			tag_s1.valid   <= (state_q == ST_QUERY);
			tag_s1.in_grid <= q_in_grid;
			tag_s1.centre  <= q_centre;
			tag_s1.ring    <= q_ring;
		end
	end

	always_comb begin
		acc_ctl       = tag_s1;
		acc_ctl.start = accept && (action == ACT_QUERY);
	end

	logic [ADC_W-1:0]  acc_centre;
	logic [RING_W-1:0] acc_ring;
	logic [WACC_W-1:0] acc_window;

	cti_window_acc u_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (acc_ctl),
		.rdata      (mem_rdata),
		.centre     (acc_centre),
		.ring_sum   (acc_ring),
		.window_sum (acc_window)
	);

	// ---------------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------------
	logic load_out;
	assign load_out = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			tower_value_q <= acc_centre;
			ring_sum_q    <= acc_ring;
			// saturate at the 13-bit maximum; flags use the exact sum
			window_sum_q  <= acc_window[WACC_W-1] ? {WIN_W{1'b1}} : acc_window[WIN_W-1:0];
			ring_iso_q    <= LIMIT_W'(acc_ring) <= iso_limit;
			window_iso_q  <= acc_window <= WACC_W'(iso_limit);
		end
	end

	assign out_valid       = out_valid_q;
	assign tower_value     = tower_value_q;
	assign ring_sum        = ring_sum_q;
	assign window_sum      = window_sum_q;
	assign ring_isolated   = ring_iso_q;
	assign window_isolated = window_iso_q;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	a_clear_writes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall && mem_we)
		else $error("clearing pass not writing or not stalling");

	a_no_write_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QUERY || state_q == ST_LAST |-> !mem_we)
		else $error("grid write during a window walk");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_ring_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		WACC_W'(acc_ring) <= acc_window)
		else $error("ring sum exceeds window sum");

endmodule

`default_nettype wire
